>>> design/assert_macros.svh
// Concurrent assertion helpers used by pure_pursuit_steering_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

>>> design/pps_pkg.sv
package pps_pkg;

   localparam int MAX_WAYPOINTS = 64;
   localparam int WP_ADDR_W     = $clog2(MAX_WAYPOINTS);
   localparam int WP_CNT_W      = $clog2(MAX_WAYPOINTS + 1);
   localparam int WP_W          = 32;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LA_SLOPE     = 3'd0,
      CSR_LA_OFFSET    = 3'd1,
      CSR_LA_BOUNDS    = 3'd2,
      CSR_WHEELBASE    = 3'd3,
      CSR_STEER_LIMIT  = 3'd4,
      CSR_STEER_THRESH = 3'd5,
      CSR_AGGR_GAINS   = 3'd6,
      CSR_SPEED_OVR    = 3'd7
   } csr_index_type;

   localparam logic [15:0] LA_SLOPE_RST     = 16'd256;
   localparam logic [15:0] LA_OFFSET_RST    = 16'd256;
   localparam logic [31:0] LA_BOUNDS_RST    = 32'd83886208;
   localparam logic [15:0] WHEELBASE_RST    = 16'd128;
   localparam logic [14:0] STEER_LIMIT_RST  = 15'd7680;
   localparam logic [31:0] STEER_THRESH_RST = 32'd0;
   localparam logic [47:0] AGGR_GAINS_RST   = 48'd16843008;
   localparam logic [16:0] SPEED_OVR_RST    = 17'd0;

   localparam int MUL_W       = 26;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int DIV_NUM_W   = 57;
   localparam int DIV_DEN_W   = 42;
   localparam int SQRT_W      = 40;
   localparam int SQRT_STEPS  = SQRT_W / 2;
   localparam int CORDIC_W    = 44;
   localparam int CORDIC_STEPS = 17;
   localparam int ANGLE_W     = 19;
   localparam int STEP_W      = $clog2(DIV_NUM_W);

   localparam int HALF_PI_Q16   = 102944;
   localparam int BIAS_Q12      = 614;
   localparam int RAD2DEG_Q16   = 3754937;
   localparam int LOW_SPEED_RAW = 25;
   localparam int CORDIC_ONE    = 65536;

   function automatic logic [ANGLE_W-1:0] atan_entry(input logic [4:0] step);
      logic [ANGLE_W-1:0] val;
      case (step)
         5'd0:    val = 19'd51472;
         5'd1:    val = 19'd30385;
         5'd2:    val = 19'd16055;
         5'd3:    val = 19'd8150;
         5'd4:    val = 19'd4091;
         5'd5:    val = 19'd2047;
         5'd6:    val = 19'd1024;
         5'd7:    val = 19'd512;
         5'd8:    val = 19'd256;
         5'd9:    val = 19'd128;
         5'd10:   val = 19'd64;
         5'd11:   val = 19'd32;
         5'd12:   val = 19'd16;
         5'd13:   val = 19'd8;
         5'd14:   val = 19'd4;
         5'd15:   val = 19'd2;
         5'd16:   val = 19'd1;
         default: val = 19'd0;
      endcase
      return val;
   endfunction

   typedef enum logic [4:0] {
      S_IDLE,
      S_LA_MUL,
      S_LA_CLAMP,
      S_LA_SQ,
      S_WALK_RD,
      S_WALK_DX,
      S_WALK_DY,
      S_WALK_CMP,
      S_HYP_X,
      S_HYP_Y,
      S_HYP_SUM,
      S_SQRT,
      S_DSQ,
      S_NUM,
      S_RATIO_START,
      S_RATIO_DIV,
      S_CORDIC,
      S_DEG_MUL,
      S_GAIN_SEL,
      S_INT_MUL,
      S_GAIN_START,
      S_GAIN_DIV,
      S_GAIN_FIX,
      S_STEER_MUL,
      S_FINISH,
      S_OUT
   } state_type;

endpackage

>>> design/pps_ram.sv
module pps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/pure_pursuit_steering_top.sv
// Pure-pursuit steering. Waypoints stream in at one beat per cycle while req_stall is low and are
// kept in a 64-entry store; further waypoints of a trajectory beyond 64 are dropped. The beat
// marked last starts the computation, during which req_stall stays high: one multiplier, a
// bit-serial divider, a digit-serial square root and a CORDIC rotator are stepped by one
// sequencer. For each waypoint examined the walk reads it, squares dx, squares dy and compares
// the sum with the squared look-ahead; then come the square root, the ratio division, the CORDIC
// and, when the angle falls in the middle band, the gain interpolation. The result sits in an
// output register, so new waypoints are taken while it waits to be drained.
`include "assert_macros.svh"

module pure_pursuit_steering_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [15:0]                 req_wp_x,
   input  logic signed [15:0]                 req_wp_y,
   input  logic signed [15:0]                 req_wp_speed,
   input  logic                               req_wp_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [15:0]                 rsp_steer_deg,
   output logic signed [15:0]                 rsp_speed_cmd,
   output logic                               rsp_path_short,
   input  logic                               csr_wr_en,
   input  logic [pps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pps_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import pps_pkg::*;

   state_type state_ff, state_in;

   logic [15:0] slope_ff;
   logic [15:0] offset_ff;
   logic [31:0] bounds_ff;
   logic [15:0] wheelbase_ff;
   logic [14:0] steer_lim_ff;
   logic [31:0] thresh_ff;
   logic [47:0] gains_ff;
   logic [16:0] ovr_ff;

   logic [WP_CNT_W-1:0] count_ff;
   logic signed [15:0]  first_speed_ff;
   logic                req_accept;

   logic                 ram_wr_en;
   logic [WP_ADDR_W-1:0] ram_wr_addr;
   logic [WP_W-1:0]      ram_wr_data;
   logic                 ram_rd_en;
   logic [WP_ADDR_W-1:0] ram_rd_addr;
   logic [WP_W-1:0]      ram_rd_data;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_full;
   logic signed [PROD_W-1:0] prod_ff;

   logic signed [15:0]  x0_ff, y0_ff, px_ff, py_ff;
   logic [23:0]         la_ff;
   logic [47:0]         la2_ff;
   logic                short_ff;
   logic [WP_CNT_W-1:0] idx_ff;
   logic [31:0]         sq_ff;

   logic [SQRT_W-1:0] sq_n_ff, sq_res_ff, sq_bit_ff;
   logic [20:0]       d_ff;

   logic [DIV_DEN_W-1:0] div_rem_ff;
   logic [DIV_NUM_W-1:0] div_sh_ff;
   logic [DIV_DEN_W-1:0] div_den_ff;
   logic                 div_neg_ff;
   logic [STEP_W-1:0]    step_ff;

   logic signed [CORDIC_W-1:0] cx_ff, cy_ff;
   logic signed [ANGLE_W-1:0]  cz_ff;

   logic [16:0]        mag_ff;
   logic [14:0]        deg_ff;
   logic [15:0]        gain_ff;
   logic signed [15:0] steer_res_ff;

   logic               rsp_valid_ff;
   logic signed [15:0] rsp_steer_ff, rsp_speed_ff;
   logic               rsp_short_ff;
   logic               rsp_load;

   logic signed [15:0] rd_x, rd_y;
   logic signed [16:0] dx, dy;
   logic signed [34:0] la_raw, la_lo, la_hi, la_c1, la_c2;
   logic [32:0]        walk_sum;
   logic               walk_hit;
   logic [32:0]        hyp_sum;
   logic [16:0]        ay;
   logic [17:0]        two_ay;

   logic [SQRT_W-1:0] sq_try, sq_n_nx, sq_res_nx;
   logic              sq_ge;

   logic [DIV_DEN_W:0]   div_trial;
   logic                 div_ge;
   logic [DIV_DEN_W-1:0] div_rem_nx;
   logic [DIV_NUM_W-1:0] div_sh_nx;
   logic                 div_last;

   logic signed [CORDIC_W-1:0] cx_sh, cy_sh, cx_nx, cy_nx;
   logic signed [ANGLE_W-1:0]  cz_step, cz_nx;
   logic [16:0]                cz_clamped;

   logic [17:0]        t1, t2;
   logic [15:0]        g1, g2, g3;
   logic signed [17:0] int_dmag;
   logic signed [16:0] int_dgain;
   logic [PROD_W-1:0]  prod_abs;
   logic signed [17:0] gain_fix;

   logic [39:0]        deg_sum;
   logic [15:0]        deg_raw;
   logic [31:0]        st_sum;
   logic [23:0]        st_raw;
   logic [14:0]        st_sat;
   logic signed [15:0] st_signed;
   logic [16:0]        v_abs;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_load   = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   assign ram_wr_en   = req_accept && (count_ff < WP_CNT_W'(MAX_WAYPOINTS));
   assign ram_wr_addr = count_ff[WP_ADDR_W-1:0];
   assign ram_wr_data = {req_wp_y, req_wp_x};

   pps_ram #(
      .WIDTH (WP_W),
      .DEPTH (MAX_WAYPOINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign mul_full = mul_a * mul_b;

   assign rd_x = $signed(ram_rd_data[15:0]);
   assign rd_y = $signed(ram_rd_data[31:16]);
   assign dx   = 17'(rd_x) - 17'(x0_ff);
   assign dy   = 17'(rd_y) - 17'(y0_ff);

   assign la_raw = 35'(prod_ff[34:0]) + $signed({{11{offset_ff[15]}}, offset_ff, 8'd0});
   assign la_lo  = $signed({11'd0, bounds_ff[15:0], 8'd0});
   assign la_hi  = $signed({11'd0, bounds_ff[31:16], 8'd0});
   assign la_c1  = (la_raw < la_lo) ? la_lo : la_raw;
   assign la_c2  = (la_c1 > la_hi) ? la_hi : la_c1;

   assign walk_sum = {1'b0, sq_ff} + {1'b0, prod_ff[31:0]};
   assign walk_hit = {walk_sum, 16'd0} >= {1'b0, la2_ff};
   assign hyp_sum  = {1'b0, sq_ff} + {1'b0, prod_ff[31:0]};

   assign ay     = py_ff[15] ? 17'(-17'(py_ff)) : 17'(py_ff);
   assign two_ay = {ay, 1'b0};

   assign sq_try    = sq_res_ff + sq_bit_ff;
   assign sq_ge     = (sq_n_ff >= sq_try);
   assign sq_n_nx   = sq_ge ? (sq_n_ff - sq_try) : sq_n_ff;
   assign sq_res_nx = sq_ge ? ((sq_res_ff >> 1) + sq_bit_ff) : (sq_res_ff >> 1);

   assign div_trial  = {div_rem_ff, div_sh_ff[DIV_NUM_W-1]};
   assign div_ge     = (div_trial >= {1'b0, div_den_ff});
   assign div_rem_nx = div_ge ? DIV_DEN_W'(div_trial - {1'b0, div_den_ff})
                              : DIV_DEN_W'(div_trial);
   assign div_sh_nx  = {div_sh_ff[DIV_NUM_W-2:0], div_ge};
   assign div_last   = (step_ff == STEP_W'(DIV_NUM_W - 1));

   assign cx_sh   = cx_ff >>> step_ff;
   assign cy_sh   = cy_ff >>> step_ff;
   assign cz_step = $signed(atan_entry(step_ff[4:0]));
   always_comb begin
      if (cy_ff > 0) begin
         cx_nx = cx_ff + cy_sh;
         cy_nx = cy_ff - cx_sh;
         cz_nx = cz_ff + cz_step;
      end else begin
         cx_nx = cx_ff - cy_sh;
         cy_nx = cy_ff + cx_sh;
         cz_nx = cz_ff - cz_step;
      end
      if (cz_nx[ANGLE_W-1]) begin
         cz_clamped = 17'd0;
      end else if (cz_nx > $signed(ANGLE_W'(HALF_PI_Q16))) begin
         cz_clamped = 17'(HALF_PI_Q16);
      end else begin
         cz_clamped = cz_nx[16:0];
      end
   end

   assign t1        = {thresh_ff[15:0], 2'b00};
   assign t2        = {thresh_ff[31:16], 2'b00};
   assign g1        = gains_ff[15:0];
   assign g2        = gains_ff[31:16];
   assign g3        = gains_ff[47:32];
   assign int_dmag  = $signed({1'b0, mag_ff} - t1);
   assign int_dgain = $signed({1'b0, g2}) - $signed({1'b0, g1});
   assign prod_abs  = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign gain_fix  = $signed({2'b00, g1})
                    + (div_neg_ff ? -$signed({1'b0, div_sh_ff[16:0]})
                                  : $signed({1'b0, div_sh_ff[16:0]}));

   assign deg_sum = {1'b0, prod_ff[38:0]} + 40'h00_0080_0000;
   assign deg_raw = deg_sum[39:24];

   assign st_sum    = prod_ff[31:0] + 32'd128;
   assign st_raw    = st_sum[31:8];
   assign st_sat    = (st_raw > 24'd32767) ? 15'h7fff : st_raw[14:0];
   assign st_signed = py_ff[15] ? -$signed({1'b0, st_sat}) : $signed({1'b0, st_sat});
   assign v_abs     = first_speed_ff[15] ? 17'(-17'(first_speed_ff)) : 17'(first_speed_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && req_wp_last) begin
               state_in = S_LA_MUL;
            end
         end
         S_LA_MUL:   state_in = S_LA_CLAMP;
         S_LA_CLAMP: state_in = S_LA_SQ;
         S_LA_SQ:    state_in = (la_ff == 24'd0) ? S_HYP_X : S_WALK_RD;
         S_WALK_RD:  state_in = (idx_ff >= count_ff) ? S_HYP_X : S_WALK_DX;
         S_WALK_DX:  state_in = S_WALK_DY;
         S_WALK_DY:  state_in = S_WALK_CMP;
         S_WALK_CMP: state_in = walk_hit ? S_HYP_X : S_WALK_RD;
         S_HYP_X:    state_in = S_HYP_Y;
         S_HYP_Y:    state_in = S_HYP_SUM;
         S_HYP_SUM:  state_in = (py_ff == 16'sd0) ? S_DEG_MUL : S_SQRT;
         S_SQRT: begin
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               state_in = S_DSQ;
            end
         end
         S_DSQ:         state_in = S_NUM;
         S_NUM:         state_in = S_RATIO_START;
         S_RATIO_START: state_in = S_RATIO_DIV;
         S_RATIO_DIV: begin
            if (div_last) begin
               state_in = (div_sh_nx == '0) ? S_DEG_MUL : S_CORDIC;
            end
         end
         S_CORDIC: begin
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = S_DEG_MUL;
            end
         end
         S_DEG_MUL: state_in = S_GAIN_SEL;
         S_GAIN_SEL: begin
            if ({1'b0, mag_ff} <= t1) begin
               state_in = S_STEER_MUL;
            end else if ({1'b0, mag_ff} <= t2) begin
               state_in = S_INT_MUL;
            end else begin
               state_in = S_STEER_MUL;
            end
         end
         S_INT_MUL:    state_in = S_GAIN_START;
         S_GAIN_START: state_in = S_GAIN_DIV;
         S_GAIN_DIV: begin
            if (div_last) begin
               state_in = S_GAIN_FIX;
            end
         end
         S_GAIN_FIX:  state_in = S_STEER_MUL;
         S_STEER_MUL: state_in = S_FINISH;
         S_FINISH:    state_in = S_OUT;
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      mul_a       = '0;
      mul_b       = '0;
      case (state_ff)
         S_LA_MUL: begin
            ram_rd_en = 1'b1;
            mul_a     = MUL_W'($signed({1'b0, slope_ff}));
            mul_b     = MUL_W'(first_speed_ff);
         end
         S_LA_SQ: begin
            mul_a = MUL_W'($signed({1'b0, la_ff}));
            mul_b = MUL_W'($signed({1'b0, la_ff}));
         end
         S_WALK_RD: begin
            ram_rd_en   = (idx_ff < count_ff);
            ram_rd_addr = idx_ff[WP_ADDR_W-1:0];
         end
         S_WALK_DX: begin
            mul_a = MUL_W'(dx);
            mul_b = MUL_W'(dx);
         end
         S_WALK_DY: begin
            mul_a = MUL_W'(dy);
            mul_b = MUL_W'(dy);
         end
         S_HYP_X: begin
            mul_a = MUL_W'(px_ff);
            mul_b = MUL_W'(px_ff);
         end
         S_HYP_Y: begin
            mul_a = MUL_W'(py_ff);
            mul_b = MUL_W'(py_ff);
         end
         S_DSQ: begin
            mul_a = MUL_W'($signed({1'b0, d_ff}));
            mul_b = MUL_W'($signed({1'b0, d_ff}));
         end
         S_NUM: begin
            mul_a = MUL_W'($signed({1'b0, two_ay}));
            mul_b = MUL_W'($signed({1'b0, wheelbase_ff}));
         end
         S_DEG_MUL: begin
            mul_a = MUL_W'($signed({1'b0, mag_ff}));
            mul_b = MUL_W'(RAD2DEG_Q16);
         end
         S_INT_MUL: begin
            mul_a = MUL_W'(int_dmag);
            mul_b = MUL_W'(int_dgain);
         end
         S_STEER_MUL: begin
            mul_a = MUL_W'($signed({1'b0, deg_ff}));
            mul_b = MUL_W'($signed({1'b0, gain_ff}));
         end
         default: begin
            ram_rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         first_speed_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         slope_ff       <= LA_SLOPE_RST;
         offset_ff      <= LA_OFFSET_RST;
         bounds_ff      <= LA_BOUNDS_RST;
         wheelbase_ff   <= WHEELBASE_RST;
         steer_lim_ff   <= STEER_LIMIT_RST;
         thresh_ff      <= STEER_THRESH_RST;
         gains_ff       <= AGGR_GAINS_RST;
         ovr_ff         <= SPEED_OVR_RST;
      end else begin
         state_ff <= state_in;
         if (ram_wr_en) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == '0) begin
               first_speed_ff <= req_wp_speed;
            end
         end
         if (rsp_load) begin
            count_ff     <= '0;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LA_SLOPE:     slope_ff     <= csr_wdata[15:0];
               CSR_LA_OFFSET:    offset_ff    <= csr_wdata[15:0];
               CSR_LA_BOUNDS:    bounds_ff    <= csr_wdata[31:0];
               CSR_WHEELBASE:    wheelbase_ff <= csr_wdata[15:0];
               CSR_STEER_LIMIT:  steer_lim_ff <= csr_wdata[14:0];
               CSR_STEER_THRESH: thresh_ff    <= csr_wdata[31:0];
               CSR_AGGR_GAINS:   gains_ff     <= csr_wdata[47:0];
               CSR_SPEED_OVR:    ovr_ff       <= csr_wdata[16:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_full;
      case (state_ff)
         S_LA_CLAMP: begin
            x0_ff <= rd_x;
            y0_ff <= rd_y;
            px_ff <= rd_x;
            py_ff <= rd_y;
            la_ff <= la_c2[23:0];
         end
         S_LA_SQ: begin
            la2_ff   <= mul_full[47:0];
            short_ff <= (la_ff != 24'd0);
            idx_ff   <= WP_CNT_W'(1);
         end
         S_WALK_DY: begin
            sq_ff <= prod_ff[31:0];
         end
         S_WALK_CMP: begin
            if (walk_hit) begin
               px_ff    <= rd_x;
               py_ff    <= rd_y;
               short_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         S_HYP_Y: begin
            sq_ff <= prod_ff[31:0];
         end
         S_HYP_SUM: begin
            sq_n_ff   <= {hyp_sum[31:0], 8'd0};
            sq_res_ff <= '0;
            sq_bit_ff <= SQRT_W'(1) << (SQRT_W - 2);
            step_ff   <= '0;
            mag_ff    <= '0;
         end
         S_SQRT: begin
            sq_n_ff   <= sq_n_nx;
            sq_res_ff <= sq_res_nx;
            sq_bit_ff <= sq_bit_ff >> 2;
            step_ff   <= step_ff + 1'b1;
            d_ff      <= 21'(sq_res_nx[20:0] + 21'(BIAS_Q12));
         end
         S_DSQ: begin
            div_den_ff <= mul_full[DIV_DEN_W-1:0];
         end
         S_RATIO_START: begin
            div_sh_ff  <= {prod_ff[32:0], 24'd0};
            div_rem_ff <= '0;
            step_ff    <= '0;
         end
         S_RATIO_DIV: begin
            div_sh_ff  <= div_sh_nx;
            div_rem_ff <= div_rem_nx;
            step_ff    <= step_ff + 1'b1;
            if (div_last) begin
               cx_ff   <= CORDIC_W'(CORDIC_ONE);
               cy_ff   <= $signed(div_sh_nx[CORDIC_W-1:0]);
               cz_ff   <= '0;
               step_ff <= '0;
            end
         end
         S_CORDIC: begin
            cx_ff   <= cx_nx;
            cy_ff   <= cy_nx;
            cz_ff   <= cz_nx;
            step_ff <= step_ff + 1'b1;
            mag_ff  <= cz_clamped;
         end
         S_GAIN_SEL: begin
            deg_ff <= (deg_raw > {1'b0, steer_lim_ff}) ? steer_lim_ff : deg_raw[14:0];
            gain_ff <= ({1'b0, mag_ff} <= t1) ? g1 : g3;
         end
         S_GAIN_START: begin
            div_sh_ff  <= DIV_NUM_W'(prod_abs);
            div_neg_ff <= prod_ff[PROD_W-1];
            div_den_ff <= DIV_DEN_W'(t2 - t1);
            div_rem_ff <= '0;
            step_ff    <= '0;
         end
         S_GAIN_DIV: begin
            div_sh_ff  <= div_sh_nx;
            div_rem_ff <= div_rem_nx;
            step_ff    <= step_ff + 1'b1;
         end
         S_GAIN_FIX: begin
            gain_ff <= gain_fix[15:0];
         end
         S_FINISH: begin
            steer_res_ff <= (v_abs <= 17'(LOW_SPEED_RAW)) ? 16'sd0 : st_signed;
         end
         default: begin
            step_ff <= step_ff;
         end
      endcase
      if (rsp_load) begin
         rsp_steer_ff <= steer_res_ff;
         rsp_speed_ff <= ovr_ff[16] ? $signed(ovr_ff[15:0])
                                    : $signed({first_speed_ff[15], first_speed_ff[15:1]});
         rsp_short_ff <= short_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_steer_deg  = rsp_steer_ff;
   assign rsp_speed_cmd  = rsp_speed_ff;
   assign rsp_path_short = rsp_short_ff;

   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > WP_CNT_W'(MAX_WAYPOINTS))
   `ASSERT_CLK(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
   `ASSERT_CLK(a_div_den_nonzero, clock, reset, (state_ff == S_RATIO_DIV || state_ff == S_GAIN_DIV) |-> (div_den_ff != '0))

endmodule
